[rtl/fks_pkg.sv]
// ----------------------------------------------------------------------------
// fks_pkg
// shared constants and types of the farthest-k unload selector
// ----------------------------------------------------------------------------
package fks_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CHUNK_EDGE = 32;

  localparam int ID_W    = 16;
  localparam int COORD_W = 16;
  localparam int CTR_W   = 21;
  localparam int RANGE_W = 20;
  localparam int DIST_W  = 44;
  localparam int CFG_W   = 21;

  // block position of a chunk center, coordinate difference and its magnitude
  localparam int POS_W  = COORD_W + $clog2(CHUNK_EDGE) + 1;
  localparam int DIFF_W = ((POS_W > CTR_W) ? POS_W : CTR_W) + 1;
  localparam int ABS_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * ABS_W;

  // entry count holds zero up to the full depth
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // op codes
  localparam logic OP_OFFER  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_CENTER_Z   = 2'd2,
    CFG_LOAD_RANGE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic unload;
  } cell_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   op;
    logic   far;
    entry_t cand;
  } cand_t;

endpackage

[rtl/fks_dist.sv]
// ----------------------------------------------------------------------------
// fks_dist
// three-stage pipeline: offset, squares, sum of squared distance
// ----------------------------------------------------------------------------
module fks_dist
  import fks_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic                      op_i,
  input  logic [ID_W-1:0]           id_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  input  logic signed [COORD_W-1:0] z_i,
  input  logic signed [CTR_W-1:0]   center_x_i,
  input  logic signed [CTR_W-1:0]   center_y_i,
  input  logic signed [CTR_W-1:0]   center_z_i,
  input  logic [RANGE_W-1:0]        load_range_i,
  output cand_t                     cand_o,
  output logic                      fin_pending_o
);

  localparam logic signed [POS_W-1:0] EdgeS   = POS_W'(CHUNK_EDGE);
  localparam logic signed [POS_W-1:0] OffsetS = POS_W'(CHUNK_EDGE / 2 - 1);

  logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
  logic signed [DIFF_W-1:0] dif_x, dif_y, dif_z;
  logic [ABS_W-1:0]         abs_x_d, abs_y_d, abs_z_d;

  // stage 1
  logic             s1_valid_q, s1_op_q;
  logic [ID_W-1:0]  s1_id_q;
  logic [ABS_W-1:0] abs_x_q, abs_y_q, abs_z_q;
  // stage 2
  logic             s2_valid_q, s2_op_q, s2_far_q;
  logic [ID_W-1:0]  s2_id_q;
  logic [SQ_W-1:0]  sq_x_q, sq_y_q, sq_z_q;
  // stage 3
  logic             s3_valid_q, s3_op_q, s3_far_q;
  logic [ID_W-1:0]  s3_id_q;
  logic [DIST_W-1:0] dist_q;

  logic [ABS_W-1:0] range_ext;
  logic             far_d;

  assign pos_x = POS_W'(x_i) * EdgeS + OffsetS;
  assign pos_y = POS_W'(y_i) * EdgeS + OffsetS;
  assign pos_z = POS_W'(z_i) * EdgeS + OffsetS;

  assign dif_x = DIFF_W'(pos_x) - DIFF_W'(center_x_i);
  assign dif_y = DIFF_W'(pos_y) - DIFF_W'(center_y_i);
  assign dif_z = DIFF_W'(pos_z) - DIFF_W'(center_z_i);

  assign abs_x_d = dif_x[DIFF_W-1] ? ABS_W'(-dif_x) : ABS_W'(dif_x);
  assign abs_y_d = dif_y[DIFF_W-1] ? ABS_W'(-dif_y) : ABS_W'(dif_y);
  assign abs_z_d = dif_z[DIFF_W-1] ? ABS_W'(-dif_z) : ABS_W'(dif_z);

  // chebyshev distance beyond range when any axis is beyond it
  assign range_ext = ABS_W'(load_range_i);
  assign far_d     = (abs_x_q > range_ext) || (abs_y_q > range_ext) ||
                     (abs_z_q > range_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q  <= op_i;
    s1_id_q  <= id_i;
    abs_x_q  <= abs_x_d;
    abs_y_q  <= abs_y_d;
    abs_z_q  <= abs_z_d;

    s2_op_q  <= s1_op_q;
    s2_id_q  <= s1_id_q;
    s2_far_q <= far_d;
    sq_x_q   <= SQ_W'(abs_x_q) * SQ_W'(abs_x_q);
    sq_y_q   <= SQ_W'(abs_y_q) * SQ_W'(abs_y_q);
    sq_z_q   <= SQ_W'(abs_z_q) * SQ_W'(abs_z_q);

    s3_op_q  <= s2_op_q;
    s3_id_q  <= s2_id_q;
    s3_far_q <= s2_far_q;
    dist_q   <= DIST_W'(sq_x_q) + DIST_W'(sq_y_q) + DIST_W'(sq_z_q);
  end

  assign cand_o.valid         = s3_valid_q;
  assign cand_o.op            = s3_op_q;
  assign cand_o.far           = s3_far_q;
  assign cand_o.cand.id       = s3_id_q;
  assign cand_o.cand.distance = dist_q;

  assign fin_pending_o = (s1_valid_q && (s1_op_q == OP_FINISH)) ||
                         (s2_valid_q && (s2_op_q == OP_FINISH)) ||
                         (s3_valid_q && (s3_op_q == OP_FINISH));

endmodule

[rtl/fks_cell.sv]
// ----------------------------------------------------------------------------
// fks_cell
// one list slot: keeps, takes the candidate, or takes a neighbor's entry
// ----------------------------------------------------------------------------
module fks_cell
  import fks_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  logic       prev_ge_i,
  input  entry_t     prev_entry_i,
  input  entry_t     next_entry_i,
  input  entry_t     cand_i,
  output entry_t     entry_o,
  output logic       ge_o
);

  entry_t entry_q, entry_d;

  // held entry stays ahead of an equal or nearer candidate
  assign ge_o = occupied_i && (entry_q.distance >= cand_i.distance);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.unload) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.insert && !ge_o) begin
      entry_d = prev_ge_i ? cand_i : prev_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/farthest_k_unload_selector.sv]
// ----------------------------------------------------------------------------
// farthest_k_unload_selector
// keeps the LIST_DEPTH farthest out-of-range chunks, farthest first
// ----------------------------------------------------------------------------
// usage
//   input channel: an item transfers on a rising edge with start_i high and
//   busy_o low. op_i offer adds a chunk, op_i finish emits the list.
//   offers may follow back to back while busy_o is low; they leave no
//   result. a finish raises busy_o while it walks the 3-stage distance
//   pipeline and while the list drains.
//   results: out_valid_o marks each result for exactly one cycle and it
//   transfers at the edge that ends that cycle; the receiver has no stall.
//   a finish passes the distance pipeline stages, then for a nonempty list
//   the unload state, which puts out one result per cycle, count results in
//   all; an empty list gives the single list_empty_o result. busy_o drops
//   with the last result on the ports.
//   throughput: offers 1 per cycle while busy_o is low, set by the
//   insertion row of cells; a finish holds busy_o until its list is out.
//   configuration: cfg_valid_i/cfg_ready_o write channel, always ready;
//   the user must write it between passes while the block is idle, which
//   the block does not enforce. reset: entry count cleared, center zero,
//   load range 256; list payload is not cleared: only occupied slots are read.
// ----------------------------------------------------------------------------
module farthest_k_unload_selector
  import fks_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      op_i,
  input  logic [ID_W-1:0]           chunk_id_i,
  input  logic signed [COORD_W-1:0] chunk_x_i,
  input  logic signed [COORD_W-1:0] chunk_y_i,
  input  logic signed [COORD_W-1:0] chunk_z_i,
  // result strobe
  output logic                      out_valid_o,
  output logic [ID_W-1:0]           out_id_o,
  output logic [DIST_W-1:0]         out_distance_o,
  output logic                      list_empty_o,
  output logic                      last_entry_o,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  typedef enum logic {
    ST_RUN,
    ST_UNLOAD
  } state_e;

  localparam logic [CNT_W-1:0] CntFull = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] CntOne  = CNT_W'(1);

  // configuration registers
  logic signed [CTR_W-1:0] center_x_q, center_y_q, center_z_q;
  logic [RANGE_W-1:0]      load_range_q;

  // control
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              empty_q, empty_d;
  logic              last_q, last_d;

  logic       accept;
  logic       fin_pending;
  cand_t      cand;
  cell_ctrl_t ctrl;
  logic       offer_far;

  entry_t entry_w [LIST_DEPTH];
  logic   ge_w    [LIST_DEPTH];

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign busy_o      = fin_pending || (state_q == ST_UNLOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      center_z_q   <= '0;
      load_range_q <= RANGE_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_X:   center_x_q   <= cfg_data_i;
        CFG_CENTER_Y:   center_y_q   <= cfg_data_i;
        CFG_CENTER_Z:   center_z_q   <= cfg_data_i;
        CFG_LOAD_RANGE: load_range_q <= cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // distance pipeline
  fks_dist u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .op_i          (op_i),
    .id_i          (chunk_id_i),
    .x_i           (chunk_x_i),
    .y_i           (chunk_y_i),
    .z_i           (chunk_z_i),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .center_z_i    (center_z_q),
    .load_range_i  (load_range_q),
    .cand_o        (cand),
    .fin_pending_o (fin_pending)
  );

  // an out-of-range offer enters the row; all cells ahead of it keep
  assign offer_far   = cand.valid && (cand.op == OP_OFFER) && cand.far;
  assign ctrl.insert = offer_far && (state_q == ST_RUN);
  assign ctrl.unload = (state_q == ST_UNLOAD);

  // insertion row: slot 0 holds the farthest entry
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic   occ;
    logic   prev_ge;
    entry_t prev_e;
    entry_t next_e;

    assign occ = (CNT_W'(k) < count_q);

    if (k == 0) begin : g_head
      assign prev_ge = 1'b1;
      assign prev_e  = cand.cand;
    end else begin : g_body
      assign prev_ge = ge_w[k-1];
      assign prev_e  = entry_w[k-1];
    end

    if (k == LIST_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entry_w[k+1];
    end

    fks_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occ),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_e),
      .next_entry_i (next_e),
      .cand_i       (cand.cand),
      .entry_o      (entry_w[k]),
      .ge_o         (ge_w[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = 1'b0;
    out_id_d    = out_id_q;
    out_dist_d  = out_dist_q;
    empty_d     = empty_q;
    last_d      = last_q;
    case (state_q)
      ST_RUN: begin
        // a candidate behind a full list's last entry is dropped
        if (ctrl.insert && !ge_w[LIST_DEPTH-1] && (count_q != CntFull)) begin
          count_d = count_q + CntOne;
        end
        if (cand.valid && (cand.op == OP_FINISH)) begin
          if (count_q == '0) begin
            out_valid_d = 1'b1;
            out_id_d    = '0;
            out_dist_d  = '0;
            empty_d     = 1'b1;
            last_d      = 1'b1;
          end else begin
            state_d = ST_UNLOAD;
          end
        end
      end
      ST_UNLOAD: begin
        // head slot goes out while the row shifts toward it
        out_valid_d = 1'b1;
        out_id_d    = entry_w[0].id;
        out_dist_d  = entry_w[0].distance;
        empty_d     = 1'b0;
        last_d      = (count_q == CntOne);
        count_d     = count_q - CntOne;
        if (count_q == CntOne) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_dist_q  <= '0;
      empty_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_id_q    <= out_id_d;
      out_dist_q  <= out_dist_d;
      empty_q     <= empty_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_id_o       = out_id_q;
  assign out_distance_o = out_dist_q;
  assign list_empty_o   = empty_q;
  assign last_entry_o   = last_q;

endmodule

[rtl/fks_checker.sv]
// ----------------------------------------------------------------------------
// fks_checker
// port-level checks of the result stream of the unload selector
// ----------------------------------------------------------------------------
module fks_checker
  import fks_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              out_valid_o,
  input logic [ID_W-1:0]   out_id_o,
  input logic [DIST_W-1:0] out_distance_o,
  input logic              list_empty_o,
  input logic              last_entry_o
);

  // an empty list is a single result
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_empty_o |-> last_entry_o)
    else $error("empty list result not marked last");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_empty_o |-> (out_id_o == '0) && (out_distance_o == '0))
    else $error("empty list result carries nonzero fields");

  // a list drains without gaps
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_entry_o |=> out_valid_o && !list_empty_o)
    else $error("gap inside an emitted list");

  // more results pending keeps the command side busy
  a_busy_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_entry_o |-> busy_o)
    else $error("not busy while list still draining");

  // list ordered farthest first
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_entry_o |=> out_distance_o <= $past(out_distance_o))
    else $error("emitted list not in descending distance order");

endmodule

bind farthest_k_unload_selector fks_checker u_fks_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .out_valid_o    (out_valid_o),
  .out_id_o       (out_id_o),
  .out_distance_o (out_distance_o),
  .list_empty_o   (list_empty_o),
  .last_entry_o   (last_entry_o)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the farthest-k unload selector
// ----------------------------------------------------------------------------
// a directed table covers the reset state, coordinate and center extremes,
// the load range boundary, equal distances and a full list. random passes
// follow: offers closed by a finish, under changing center and range
// settings. every accepted command runs through a local copy of the sorted
// list, and each result strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fks_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 16;       // well past the result latency
  localparam int MAX_CYCLES   = 200000;
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_GAP      = 19;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
    logic              empty;
    logic              last;
  } result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cmd_t             cmd;
    int unsigned      rep;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    bit               typed;
    result_t          want;
  } row_t;

  localparam result_t EMPTY_MARK = '{id: '0, distance: '0, empty: 1'b1, last: 1'b1};

  // dut ports
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic               busy_o;
  logic               op_i        = OP_OFFER;
  logic [ID_W-1:0]    chunk_id_i  = '0;
  logic [COORD_W-1:0] chunk_x_i   = '0;
  logic [COORD_W-1:0] chunk_y_i   = '0;
  logic [COORD_W-1:0] chunk_z_i   = '0;
  logic               out_valid_o;
  logic [ID_W-1:0]    out_id_o;
  logic [DIST_W-1:0]  out_distance_o;
  logic               list_empty_o;
  logic               last_entry_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_data_i  = '0;

  // local copy of the configuration and of the sorted list
  longint ctr_x     = 0;
  longint ctr_y     = 0;
  longint ctr_z     = 0;
  longint range_lim = 256;
  entry_t held[LIST_DEPTH];
  int     held_count = 0;

  result_t due_results[$];
  row_t    dir_rows[$];
  int      fail_count  = 0;
  int      cycle_count = 0;
  int      sent_count  = 0;
  bit      burst       = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  farthest_k_unload_selector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .chunk_id_i    (chunk_id_i),
    .chunk_x_i     (chunk_x_i),
    .chunk_y_i     (chunk_y_i),
    .chunk_z_i     (chunk_z_i),
    .out_valid_o   (out_valid_o),
    .out_id_o      (out_id_o),
    .out_distance_o(out_distance_o),
    .list_empty_o  (list_empty_o),
    .last_entry_o  (last_entry_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // list model
  // ---------------------------------------------------------------------------

  // block position of a chunk center on one axis
  function automatic longint center_block(logic [COORD_W-1:0] c);
    return longint'($signed(c)) * CHUNK_EDGE + CHUNK_EDGE / 2 - 1;
  endfunction

  function automatic longint axis_gap(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void apply_cfg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_CENTER_X:   ctr_x = longint'($signed(data));
      CFG_CENTER_Y:   ctr_y = longint'($signed(data));
      CFG_CENTER_Z:   ctr_z = longint'($signed(data));
      CFG_LOAD_RANGE: range_lim = longint'(data[RANGE_W-1:0]);
      default: ;
    endcase
  endfunction

  // offers update the list, a finish drains it into results
  function automatic void update_list(input cmd_t c, output result_t res[$]);
    longint            dx;
    longint            dy;
    longint            dz;
    longint            cheb;
    logic [DIST_W-1:0] d;
    int                slot;
    int                j;
    res = {};
    if (c.op == OP_OFFER) begin
      dx   = axis_gap(center_block(c.x), ctr_x);
      dy   = axis_gap(center_block(c.y), ctr_y);
      dz   = axis_gap(center_block(c.z), ctr_z);
      cheb = dx;
      if (dy > cheb) cheb = dy;
      if (dz > cheb) cheb = dz;
      // still inside the load range: nothing to unload
      if (cheb <= range_lim) return;
      d    = DIST_W'(dx * dx + dy * dy + dz * dz);
      // ties land behind the entries already held
      slot = 0;
      while (slot < held_count && held[slot].distance >= d) slot++;
      if (slot >= LIST_DEPTH) return;
      for (j = LIST_DEPTH - 1; j > slot; j--) held[j] = held[j-1];
      held[slot].id       = c.id;
      held[slot].distance = d;
      if (held_count < LIST_DEPTH) held_count++;
    end else if (held_count == 0) begin
      res.push_back(EMPTY_MARK);
    end else begin
      for (j = 0; j < held_count; j++) begin
        res.push_back('{id: held[j].id, distance: held[j].distance, empty: 1'b0,
                        last: (j == held_count - 1)});
      end
      held_count = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [DIST_W-1:0] want,
                                      logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // results cannot be held off, so every strobe is a transfer
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: id %0d distance %0d", out_id_o, out_distance_o);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("out_id", DIST_W'(want.id), DIST_W'(out_id_o));
        check_field("out_distance", want.distance, out_distance_o);
        check_field("list_empty", DIST_W'(want.empty), DIST_W'(list_empty_o));
        check_field("last_entry", DIST_W'(want.last), DIST_W'(last_entry_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic int unsigned sender_gap();
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // one command transfer; the start strobe stays up for a back-to-back follower
  task automatic send_cmd(input cmd_t c, input int unsigned gap, input bit typed,
                          input result_t want);
    result_t res[$];
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    op_i       <= c.op;
    chunk_id_i <= c.id;
    chunk_x_i  <= c.x;
    chunk_y_i  <= c.y;
    chunk_z_i  <= c.z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    update_list(c, res);
    if (typed) due_results.push_back(want);
    else foreach (res[i]) due_results.push_back(res[i]);
    sent_count++;
  endtask

  // registers change only with the list drained and the pipeline empty
  task automatic wait_idle();
    start_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // valid stays up across a batch of writes; the caller lowers it
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_cfg(idx, data);
  endtask

  function automatic row_t cmd_row(logic op, logic [ID_W-1:0] id, int x, int y, int z,
                                   int unsigned rep = 1, bit typed = 1'b0,
                                   result_t want = '0);
    row_t r;
    r.kind  = ROW_CMD;
    r.cmd   = '{op: op, id: id, x: COORD_W'(x), y: COORD_W'(y), z: COORD_W'(z)};
    r.rep   = rep;
    r.idx   = CFG_CENTER_X;
    r.data  = '0;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_idx_e idx, int data);
    row_t r;
    r       = cmd_row(OP_OFFER, '0, 0, 0, 0);
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = CFG_W'(data);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_center();
    case ($urandom_range(0, 7))
      0:       return CFG_W'(-1048576);
      1:       return CFG_W'(1048575);
      default: return CFG_W'($urandom());
    endcase
  endfunction

  // bit 20 of a range write is ignored, so it is driven at random
  function automatic logic [CFG_W-1:0] pick_range();
    case ($urandom_range(0, 9))
      0:       return {1'($urandom()), 20'd0};
      1:       return {1'($urandom()), 20'hFFFFF};
      2:       return CFG_W'($urandom());
      default: return {1'($urandom()), 20'($urandom_range(0, 400))};
    endcase
  endfunction

  // chunk coordinate near the center chunk, at an extreme, or anywhere
  function automatic logic [COORD_W-1:0] pick_coord(longint ctr, int unsigned mode);
    case (mode)
      0:       return COORD_W'($urandom());
      1:       return ($urandom_range(0, 1) != 0) ? COORD_W'(-32768) : COORD_W'(32767);
      default: return COORD_W'((ctr >>> 5) + longint'($urandom_range(0, 24)) - 12);
    endcase
  endfunction

  function automatic cmd_t rand_offer();
    cmd_t        c;
    int unsigned mode;
    mode = $urandom_range(0, 7);
    c.op = OP_OFFER;
    c.id = ID_W'($urandom());
    c.x  = pick_coord(ctr_x, mode);
    c.y  = pick_coord(ctr_y, mode);
    c.z  = pick_coord(ctr_z, mode);
    return c;
  endfunction

  // directed rows: typed expectations where the value is plain to see
  task automatic build_table();
    // finish straight after reset; its id and coordinates are ignored
    dir_rows.push_back(cmd_row(OP_FINISH, 16'hA5A5, -1, 0, 1, 1, 1'b1, EMPTY_MARK));
    // inside the default range, then the most negative chunk
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0001, 0, 0, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'hFFFF, -32768, -32768, -32768));
    dir_rows.push_back(cmd_row(OP_FINISH, 16'h0000, 0, 0, 0, 1, 1'b1,
                               '{id: 16'hFFFF, distance: 44'd3298440512163,
                                 empty: 1'b0, last: 1'b1}));
    // most positive chunk, two chunks at equal distance, one just inside
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0000, 32767, 32767, 32767));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0011, 8, 0, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0012, 0, 8, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0013, 7, -1, 0));
    dir_rows.push_back(cmd_row(OP_FINISH, 16'hFFFF, 32767, -32768, 0));
    // chebyshev distance equal to the range keeps a chunk loaded
    dir_rows.push_back(cfg_row(CFG_LOAD_RANGE, 271));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0021, 8, 0, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0022, 0, 0, -9));
    dir_rows.push_back(cmd_row(OP_FINISH, 16'h0000, 0, 0, 0));
    // center in an extreme corner, zero range: the largest distances
    dir_rows.push_back(cfg_row(CFG_CENTER_X, -1048576));
    dir_rows.push_back(cfg_row(CFG_CENTER_Y, 1048575));
    dir_rows.push_back(cfg_row(CFG_CENTER_Z, -1048576));
    dir_rows.push_back(cfg_row(CFG_LOAD_RANGE, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0031, 32767, -32768, 32767));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0032, -32768, 32767, -32768));
    dir_rows.push_back(cmd_row(OP_FINISH, 16'h0000, 0, 0, 0));
    // widest range, top data bit set: a chunk just inside it stays loaded
    dir_rows.push_back(cfg_row(CFG_LOAD_RANGE, 'h1FFFFF));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0041, -1, 0, -1));
    dir_rows.push_back(cmd_row(OP_FINISH, 16'h0000, 0, 0, 0, 1, 1'b1, EMPTY_MARK));
    // full list: sixteen ever farther chunks, then a nearer one, a farther
    // one that pushes the nearest out, and one tying the new last entry
    dir_rows.push_back(cfg_row(CFG_CENTER_X, 0));
    dir_rows.push_back(cfg_row(CFG_CENTER_Y, 0));
    dir_rows.push_back(cfg_row(CFG_CENTER_Z, 0));
    dir_rows.push_back(cfg_row(CFG_LOAD_RANGE, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0100, 100, 0, 0, LIST_DEPTH));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0200, 50, 0, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0300, 200, 0, 0));
    dir_rows.push_back(cmd_row(OP_OFFER, 16'h0400, 101, 0, 0));
    dir_rows.push_back(cmd_row(OP_FINISH, 16'h0000, 0, 0, 0));
  endtask

  initial begin
    row_kind_e   prev_kind;
    cmd_t        c;
    int          target;
    int unsigned phase_kind;
    int unsigned offers;

    for (int i = 0; i < LIST_DEPTH; i++) held[i] = '0;
    build_table();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    prev_kind = ROW_CMD;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (prev_kind == ROW_CMD) wait_idle();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        if (prev_kind == ROW_CFG) cfg_valid_i <= 1'b0;
        for (int k = 0; k < dir_rows[r].rep; k++) begin
          c    = dir_rows[r].cmd;
          c.id = c.id + ID_W'(k);
          c.x  = c.x + COORD_W'(k);
          send_cmd(c, sender_gap(), dir_rows[r].typed, dir_rows[r].want);
        end
      end
      prev_kind = dir_rows[r].kind;
    end

    // random passes: optional new settings, a run of offers, one finish
    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      phase_kind = $urandom_range(0, 9);
      burst      = ($urandom_range(0, 3) == 0);
      if (phase_kind < 6) begin
        wait_idle();
        if ($urandom_range(0, 1) != 0) write_reg(CFG_CENTER_X, pick_center());
        if ($urandom_range(0, 1) != 0) write_reg(CFG_CENTER_Y, pick_center());
        if ($urandom_range(0, 1) != 0) write_reg(CFG_CENTER_Z, pick_center());
        if ($urandom_range(0, 1) != 0) write_reg(CFG_LOAD_RANGE, pick_range());
        cfg_valid_i <= 1'b0;
      end else if (phase_kind == 6) begin
        // hold off until the last list has come out
        start_i <= 1'b0;
        @(posedge clk_i);
        while (due_results.size() != 0) @(posedge clk_i);
      end
      // mostly short passes, now and then one that overflows the list
      offers = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 40)
                                           : $urandom_range(0, 16);
      repeat (offers) send_cmd(rand_offer(), sender_gap(), 1'b0, '0);
      c = '{op: OP_FINISH, id: ID_W'($urandom()), x: COORD_W'($urandom()),
            y: COORD_W'($urandom()), z: COORD_W'($urandom())};
      send_cmd(c, sender_gap(), 1'b0, '0);
    end

    start_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
